// File: rtl/pcg_pkg.sv
// Shared types and constants for the RGBA pixel color grade pipeline.
`timescale 1ns / 1ps

package pcg_pkg;

  // Transaction codes on the input channel.
  localparam logic OP_GRADE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Tone table selectors carried by load transactions.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CHANNEL_CODE [3] = '{CH_RED, CH_GREEN, CH_BLUE};

  // Configuration register indexes.
  localparam logic [1:0] CFG_CONTRAST   = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd1;
  localparam logic [1:0] CFG_SATURATION = 2'd2;
  localparam logic [1:0] CFG_CURVES     = 2'd3;

  localparam logic [14:0] CONTRAST_RESET   = 15'd4096;
  localparam logic [14:0] SATURATION_RESET = 15'd4096;

  // Rec.709 luma weights scaled by LUMA_SCALE.
  localparam int LUMA_R     = 2126;
  localparam int LUMA_G     = 7152;
  localparam int LUMA_B     = 722;
  localparam int LUMA_SCALE = 10000;

  // Final scaling: level = floor(u / LEVEL_DIV), u already carries the half-LSB bias.
  localparam int QW = 24;
  localparam int ROUND_BIAS = 20000;
  localparam logic [QW-1:0] LEVEL_DIV   = 24'd40000;
  localparam logic [QW-1:0] CLAMP_LIMIT = 24'd10240000;

  // Reciprocal of LEVEL_DIV, scaled by 2^RECIP_SHIFT and rounded down.
  localparam int RW = 22;
  localparam logic [RW-1:0] RECIP_M = 22'd3435973;
  localparam int RECIP_SHIFT = 37;

  typedef struct packed {
    logic [14:0]        contrast_gain;
    logic signed [13:0] brightness_lift;
    logic [14:0]        saturation_gain;
    logic               curves_enable;
  } pcg_cfg_t;

endpackage

// File: rtl/pcg_tone_lut.sv
// First pipeline stage: tone table storage, table loads and table lookup.
`timescale 1ns / 1ps

module pcg_tone_lut (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            i_valid,
  output logic            o_ready,
  input  logic            i_operation,
  input  logic [7:0]      i_red,
  input  logic [7:0]      i_green,
  input  logic [7:0]      i_blue,
  input  logic [7:0]      i_alpha,
  input  logic [1:0]      i_table_channel,
  input  logic [7:0]      i_table_index,
  input  logic [7:0]      i_table_value,
  input  logic            i_curves_enable,
  output logic            o_valid,
  input  logic            i_ready,
  output logic [2:0][7:0] o_level,
  output logic [7:0]      o_alpha
);
  import pcg_pkg::*;

  logic            s1_valid_r;
  logic [2:0][7:0] raw_r;
  logic [7:0]      alpha_r;
  logic [2:0][7:0] pix;
  logic            take;
  logic            grade;
  logic            load;

  assign pix     = {i_blue, i_green, i_red};
  assign o_ready = !s1_valid_r || i_ready;
  assign take    = i_valid && o_ready;
  assign grade   = take && (i_operation == OP_GRADE);
  assign load    = take && (i_operation == OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (o_ready) begin
      // Load transactions update a table and leave a bubble behind.
      s1_valid_r <= i_valid && (i_operation == OP_GRADE);
    end
  end

  always_ff @(posedge clk) begin
    if (grade) begin
      raw_r   <= pix;
      alpha_r <= i_alpha;
    end
  end

  for (genvar lane = 0; lane < 3; lane++) begin : g_lane
    logic [7:0] tone_mem_r [256];
    logic [7:0] rd_r;

    always_ff @(posedge clk) begin
      if (load && (i_table_channel == CHANNEL_CODE[lane])) begin
        tone_mem_r[i_table_index] <= i_table_value;
      end
      if (grade) begin
        rd_r <= tone_mem_r[pix[lane]];
      end
    end

    assign o_level[lane] = i_curves_enable ? rd_r : raw_r[lane];
  end

  assign o_valid = s1_valid_r;
  assign o_alpha = alpha_r;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (i_valid && o_ready && (i_operation == OP_LOAD)) |=> !s1_valid_r)
    else $error("load transaction entered the grading pipeline");

endmodule

// File: rtl/pcg_levels.sv
// Stages two to four: contrast and brightness levels, luma, and chroma offset.
`timescale 1ns / 1ps

module pcg_levels #(
  parameter int GAIN_FRAC_BITS = 12,
  localparam int LW = ((GAIN_FRAC_BITS > 15) ? GAIN_FRAC_BITS : 15) + 12,
  localparam int YW = LW + 15,
  localparam int DW = LW + 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcg_pkg::pcg_cfg_t    i_cfg,
  input  logic                 i_valid,
  output logic                 o_ready,
  input  logic [2:0][7:0]      i_level,
  input  logic [7:0]           i_alpha,
  output logic                 o_valid,
  input  logic                 i_ready,
  output logic signed [DW-1:0] o_diff [3],
  output logic signed [YW-1:0] o_luma,
  output logic [7:0]           o_alpha
);
  import pcg_pkg::*;

  localparam logic signed [LW-1:0] GainOne = LW'(1) << GAIN_FRAC_BITS;

  logic s2_valid_r, s3_valid_r, s4_valid_r;
  logic rdy2, rdy3, rdy4;

  logic signed [LW-1:0] c_s, b_s, offset;
  logic signed [LW-1:0] v_s    [3];
  logic signed [LW-1:0] lv_nxt [3];
  logic signed [LW-1:0] lv_r   [3];
  logic signed [LW-1:0] lv3_r  [3];
  logic signed [YW-1:0] y_nxt, y_r;
  logic signed [DW-1:0] diff_nxt [3];
  logic signed [DW-1:0] diff_r   [3];
  logic signed [YW-1:0] y4_r;
  logic [7:0]           a2_r, a3_r, a4_r;

  assign rdy4    = !s4_valid_r || i_ready;
  assign rdy3    = !s3_valid_r || rdy4;
  assign rdy2    = !s2_valid_r || rdy3;
  assign o_ready = rdy2;

  // Level in units of 2^-(GAIN_FRAC_BITS+1): 2*v*c + 255*(1-c) + 510*b.
  always_comb begin
    c_s    = LW'(i_cfg.contrast_gain);
    b_s    = LW'(i_cfg.brightness_lift);
    offset = LW'(255 * (GainOne - c_s) + 510 * b_s);
    for (int k = 0; k < 3; k++) begin
      v_s[k]    = LW'(i_level[k]);
      lv_nxt[k] = LW'(2 * v_s[k] * c_s + offset);
    end
  end

  always_comb begin
    y_nxt = YW'(LUMA_R * YW'(lv_r[0]) + LUMA_G * YW'(lv_r[1]) + LUMA_B * YW'(lv_r[2]));
  end

  // Offset of each channel from luma, scaled by the luma weight total.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_nxt[k] = DW'(LUMA_SCALE * DW'(lv3_r[k]) - DW'(y_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_valid_r <= i_valid;
      end
      if (rdy3) begin
        s3_valid_r <= s2_valid_r;
      end
      if (rdy4) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && i_valid) begin
      lv_r <= lv_nxt;
      a2_r <= i_alpha;
    end
    if (rdy3 && s2_valid_r) begin
      lv3_r <= lv_r;
      y_r   <= y_nxt;
      a3_r  <= a2_r;
    end
    if (rdy4 && s3_valid_r) begin
      diff_r <= diff_nxt;
      y4_r   <= y_r;
      a4_r   <= a3_r;
    end
  end

  assign o_valid = s4_valid_r;
  assign o_diff  = diff_r;
  assign o_luma  = y4_r;
  assign o_alpha = a4_r;

endmodule

// File: rtl/pcg_saturate.sv
// Stages five to eight: saturation blend, rounding, division by constant and clamp.
`timescale 1ns / 1ps

module pcg_saturate #(
  parameter int GAIN_FRAC_BITS = 12,
  localparam int LW = ((GAIN_FRAC_BITS > 15) ? GAIN_FRAC_BITS : 15) + 12,
  localparam int YW = LW + 15,
  localparam int DW = LW + 16,
  localparam int PW = DW + 16,
  localparam int NW = PW + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [14:0]          i_saturation_gain,
  input  logic                 i_valid,
  output logic                 o_ready,
  input  logic signed [DW-1:0] i_diff [3],
  input  logic signed [YW-1:0] i_luma,
  input  logic [7:0]           i_alpha,
  output logic                 o_valid,
  input  logic                 i_ready,
  output logic [2:0][7:0]      o_level,
  output logic [7:0]           o_alpha
);
  import pcg_pkg::*;

  localparam int MW = QW + RW;

  logic s5_valid_r, s6_valid_r, s7_valid_r, s8_valid_r;
  logic rdy5, rdy6, rdy7, rdy8;

  logic signed [PW-1:0] s_s;
  logic signed [PW-1:0] p_nxt [3];
  logic signed [PW-1:0] p_r   [3];
  logic signed [YW-1:0] y5_r;
  logic signed [NW-1:0] num   [3];
  logic signed [NW-1:0] ufull [3];
  logic [QW-1:0]        u_nxt [3];
  logic [QW-1:0]        u6_r  [3];
  logic [QW-1:0]        u7_r  [3];
  logic [2:0]           neg_nxt, ovf_nxt;
  logic [2:0]           neg6_r, ovf6_r, neg7_r, ovf7_r;
  logic [MW-1:0]        prod  [3];
  logic [7:0]           q0_nxt [3];
  logic [7:0]           q0_r   [3];
  logic [QW:0]          rem   [3];
  logic [2:0][7:0]      lvl_nxt;
  logic [2:0][7:0]      lvl_r;
  logic [7:0]           a5_r, a6_r, a7_r, a8_r;
  logic                 u_in_range;
  logic                 est_ok;

  assign rdy8    = !s8_valid_r || i_ready;
  assign rdy7    = !s7_valid_r || rdy8;
  assign rdy6    = !s6_valid_r || rdy7;
  assign rdy5    = !s5_valid_r || rdy6;
  assign o_ready = rdy5;

  always_comb begin
    s_s = PW'(i_saturation_gain);
    for (int k = 0; k < 3; k++) begin
      p_nxt[k] = PW'(s_s * PW'(i_diff[k]));
    end
  end

  // num = s*diff + luma*2^F; u = floor(num / 2^(2F-1)) + bias folds in the half step.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k]     = NW'(p_r[k]) + (NW'(y5_r) <<< GAIN_FRAC_BITS);
      ufull[k]   = (num[k] >>> (2 * GAIN_FRAC_BITS - 1)) + NW'(ROUND_BIAS);
      neg_nxt[k] = ufull[k] < 0;
      ovf_nxt[k] = ufull[k] >= $signed(NW'(CLAMP_LIMIT));
      u_nxt[k]   = (neg_nxt[k] || ovf_nxt[k]) ? '0 : ufull[k][QW-1:0];
    end
  end

  // Reciprocal estimate, at most one below the true quotient.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k]   = MW'(u6_r[k]) * MW'(RECIP_M);
      q0_nxt[k] = prod[k][RECIP_SHIFT +: 8];
    end
  end

  always_comb begin
    est_ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      rem[k] = (QW + 1)'(u7_r[k]) - (QW + 1)'(q0_r[k]) * (QW + 1)'(LEVEL_DIV);
      if (neg7_r[k]) begin
        lvl_nxt[k] = 8'd0;
      end else if (ovf7_r[k]) begin
        lvl_nxt[k] = 8'hFF;
      end else begin
        lvl_nxt[k] = q0_r[k] + 8'(rem[k] >= (QW + 1)'(LEVEL_DIV));
      end
      if (rem[k] >= (QW + 1)'(2) * (QW + 1)'(LEVEL_DIV)) begin
        est_ok = 1'b0;
      end
    end
  end

  always_comb begin
    u_in_range = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (u6_r[k] >= CLAMP_LIMIT) begin
        u_in_range = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else begin
      if (rdy5) begin
        s5_valid_r <= i_valid;
      end
      if (rdy6) begin
        s6_valid_r <= s5_valid_r;
      end
      if (rdy7) begin
        s7_valid_r <= s6_valid_r;
      end
      if (rdy8) begin
        s8_valid_r <= s7_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && i_valid) begin
      p_r  <= p_nxt;
      y5_r <= i_luma;
      a5_r <= i_alpha;
    end
    if (rdy6 && s5_valid_r) begin
      u6_r   <= u_nxt;
      neg6_r <= neg_nxt;
      ovf6_r <= ovf_nxt;
      a6_r   <= a5_r;
    end
    if (rdy7 && s6_valid_r) begin
      q0_r   <= q0_nxt;
      u7_r   <= u6_r;
      neg7_r <= neg6_r;
      ovf7_r <= ovf6_r;
      a7_r   <= a6_r;
    end
    if (rdy8 && s7_valid_r) begin
      lvl_r <= lvl_nxt;
      a8_r  <= a7_r;
    end
  end

  assign o_valid = s8_valid_r;
  assign o_level = lvl_r;
  assign o_alpha = a8_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s6_valid_r |-> ((neg6_r & ovf6_r) == 3'b000))
    else $error("level flagged both below zero and above full scale");

  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    s6_valid_r |-> u_in_range)
    else $error("scaled level escaped the clamp range");

  a_recip_estimate: assert property (@(posedge clk) disable iff (!rst_n)
    s7_valid_r |-> est_ok)
    else $error("reciprocal quotient estimate off by more than one");

endmodule

// File: rtl/rgba_pixel_colour_grade_unit.sv
// Top level of the RGBA pixel color grade unit: configuration registers and pipeline.
`timescale 1ns / 1ps

// Usage:
// Input channel (in_valid / in_stall) carries one transaction per accepted edge:
// either a pixel to grade or a write of one tone table entry. Load transactions
// update the tables at acceptance and produce no result.
// Output channel (out_valid / out_stall) returns one graded pixel per grade
// transaction, in order.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_wdata) is always ready; the user
// must write it only while the pipeline is empty, which the block does not enforce.
// A graded pixel passes through one table stage, three level stages and four blend
// and scaling stages before it is presented on the output.
// Throughput: one transaction per clock while nothing stalls; each stage holds its own valid bit.
// When out_stall is high the output register holds; upstream stages keep filling
// empty slots until the first stage is full, then in_stall rises.
// Reset clears every valid bit and loads the register reset values; the tone
// tables hold nothing defined until loaded.
module rgba_pixel_colour_grade_unit #(
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic [7:0]  in_alpha_in,
  input  logic [1:0]  in_table_channel,
  input  logic [7:0]  in_table_index,
  input  logic [7:0]  in_table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import pcg_pkg::*;

  localparam int LW = ((GAIN_FRAC_BITS > 15) ? GAIN_FRAC_BITS : 15) + 12;
  localparam int YW = LW + 15;
  localparam int DW = LW + 16;

  pcg_cfg_t cfg_r;

  logic            lut_ready, lut_valid;
  logic [2:0][7:0] lut_level;
  logic [7:0]      lut_alpha;

  logic                 lvl_ready, lvl_valid;
  logic signed [DW-1:0] lvl_diff [3];
  logic signed [YW-1:0] lvl_luma;
  logic [7:0]           lvl_alpha;

  logic            sat_ready;
  logic [2:0][7:0] sat_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{contrast_gain: CONTRAST_RESET, brightness_lift: 14'sd0,
                 saturation_gain: SATURATION_RESET, curves_enable: 1'b0};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONTRAST:   cfg_r.contrast_gain   <= cfg_wdata;
        CFG_BRIGHTNESS: cfg_r.brightness_lift <= $signed(cfg_wdata[13:0]);
        CFG_SATURATION: cfg_r.saturation_gain <= cfg_wdata;
        CFG_CURVES:     cfg_r.curves_enable   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !lut_ready;

  pcg_tone_lut u_lut (
    .clk             (clk),
    .rst_n           (rst_n),
    .i_valid         (in_valid),
    .o_ready         (lut_ready),
    .i_operation     (in_operation),
    .i_red           (in_red_in),
    .i_green         (in_green_in),
    .i_blue          (in_blue_in),
    .i_alpha         (in_alpha_in),
    .i_table_channel (in_table_channel),
    .i_table_index   (in_table_index),
    .i_table_value   (in_table_value),
    .i_curves_enable (cfg_r.curves_enable),
    .o_valid         (lut_valid),
    .i_ready         (lvl_ready),
    .o_level         (lut_level),
    .o_alpha         (lut_alpha)
  );

  pcg_levels #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_levels (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_cfg   (cfg_r),
    .i_valid (lut_valid),
    .o_ready (lvl_ready),
    .i_level (lut_level),
    .i_alpha (lut_alpha),
    .o_valid (lvl_valid),
    .i_ready (sat_ready),
    .o_diff  (lvl_diff),
    .o_luma  (lvl_luma),
    .o_alpha (lvl_alpha)
  );

  pcg_saturate #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_saturate (
    .clk               (clk),
    .rst_n             (rst_n),
    .i_saturation_gain (cfg_r.saturation_gain),
    .i_valid           (lvl_valid),
    .o_ready           (sat_ready),
    .i_diff            (lvl_diff),
    .i_luma            (lvl_luma),
    .i_alpha           (lvl_alpha),
    .o_valid           (out_valid),
    .i_ready           (!out_stall),
    .o_level           (sat_level),
    .o_alpha           (out_alpha_out)
  );

  assign out_red_out   = sat_level[0];
  assign out_green_out = sat_level[1];
  assign out_blue_out  = sat_level[2];

endmodule
